@@ rtl/bez_pkg.sv @@
// shared constants for the cubic bezier point evaluator
// register indexes, default widths and pipeline depth; no dependencies
`timescale 1ns / 1ps

package bez_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = 4;
  localparam int PIPE_STAGES = 6;

  localparam logic [REG_IDX_W-1:0] REG_P0_X = 4'd0;
  localparam logic [REG_IDX_W-1:0] REG_P0_Y = 4'd1;
  localparam logic [REG_IDX_W-1:0] REG_P1_X = 4'd2;
  localparam logic [REG_IDX_W-1:0] REG_P1_Y = 4'd3;
  localparam logic [REG_IDX_W-1:0] REG_P2_X = 4'd4;
  localparam logic [REG_IDX_W-1:0] REG_P2_Y = 4'd5;
  localparam logic [REG_IDX_W-1:0] REG_P3_X = 4'd6;
  localparam logic [REG_IDX_W-1:0] REG_P3_Y = 4'd7;

endpackage

@@ rtl/cubic_bezier_point_eval.sv @@
// Cubic Bezier point evaluator. Four control points are written through the
// register port (index 0..7 = p0_x, p0_y .. p3_x, p3_y; other indexes are
// ignored). Each item carries t in unsigned Q1.16 (values above 1.0 act as
// 1.0) and returns one point, the exact Bernstein sum truncated toward zero.
// The block takes one item per clock while in_stall is low and is fully
// pipelined. Its six register stages are t products, weights, split
// coordinate products, partial sums, accumulation and truncation. Empty stages
// absorb stalls, so items are taken until all six stages hold waiting results.
// Depends on bez_pkg, bez_weight and bez_axis.
`timescale 1ns / 1ps

module cubic_bezier_point_eval #(
  parameter int COORD_BITS  = bez_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = bez_pkg::T_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bez_pkg::REG_IDX_W-1:0]  cfg_addr,
  input  logic [COORD_BITS-1:0]          cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [T_FRAC_BITS:0]           t_param,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [COORD_BITS-1:0]   point_x,
  output logic signed [COORD_BITS-1:0]   point_y
);
  import bez_pkg::*;

  localparam int WB = 3 * T_FRAC_BITS + 1;

  logic signed [COORD_BITS-1:0] p0_x, p0_y, p1_x, p1_y;
  logic signed [COORD_BITS-1:0] p2_x, p2_y, p3_x, p3_y;

  logic [PIPE_STAGES:1]   v;
  logic [PIPE_STAGES+1:1] ready;
  logic [PIPE_STAGES:1]   ld;
  logic [PIPE_STAGES-1:0] v_in;

  logic [3:0][WB-1:0] weight;

  // control point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_x <= '0;
      p0_y <= '0;
      p1_x <= '0;
      p1_y <= '0;
      p2_x <= '0;
      p2_y <= '0;
      p3_x <= '0;
      p3_y <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_P0_X: p0_x <= cfg_wdata;
        REG_P0_Y: p0_y <= cfg_wdata;
        REG_P1_X: p1_x <= cfg_wdata;
        REG_P1_Y: p1_y <= cfg_wdata;
        REG_P2_X: p2_x <= cfg_wdata;
        REG_P2_Y: p2_y <= cfg_wdata;
        REG_P3_X: p3_x <= cfg_wdata;
        REG_P3_Y: p3_y <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a stage can load when it is empty or the stage after it moves
  always_comb begin
    v_in = {v[PIPE_STAGES-1:1], in_valid};
    ready[PIPE_STAGES+1] = !out_stall;
    for (int k = PIPE_STAGES; k >= 1; k--) begin
      ready[k] = !v[k] || ready[k+1];
    end
    for (int k = 1; k <= PIPE_STAGES; k++) begin
      ld[k] = ready[k] && v_in[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= PIPE_STAGES; k++) begin
        if (ready[k]) begin
          v[k] <= v_in[k-1];
        end
      end
    end
  end

  assign in_stall  = !ready[1];
  assign out_valid = v[PIPE_STAGES];

  bez_weight #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_weight (
    .clk     (clk),
    .rst     (rst),
    .ld      (ld[2:1]),
    .t_param (t_param),
    .weight  (weight)
  );

  bez_axis #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_axis_x (
    .clk    (clk),
    .ld     (ld[6:3]),
    .weight (weight),
    .c0     (p0_x),
    .c1     (p1_x),
    .c2     (p2_x),
    .c3     (p3_x),
    .point  (point_x)
  );

  bez_axis #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_axis_y (
    .clk    (clk),
    .ld     (ld[6:3]),
    .weight (weight),
    .c0     (p0_y),
    .c1     (p1_y),
    .c2     (p2_y),
    .c3     (p3_y),
    .point  (point_y)
  );

  a_first_open: assert property (@(posedge clk) disable iff (rst)
    !v[1] |-> !in_stall)
    else $error("item refused with first stage empty");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !v[PIPE_STAGES-1] |=> !out_valid)
    else $error("result repeated after it was taken");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !v[1])
    else $error("pipeline not empty after reset");

endmodule

@@ rtl/bez_weight.sv @@
// bernstein weight pipeline: two stages from t to the four cubic weights
// depends on bez_pkg for default widths
`timescale 1ns / 1ps

module bez_weight #(
  parameter int T_FRAC_BITS = bez_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [1:0]                          ld,
  input  logic [T_FRAC_BITS:0]                t_param,
  output logic [3:0][3*T_FRAC_BITS:0]         weight
);
  import bez_pkg::*;

  localparam int TW = T_FRAC_BITS + 1;
  localparam int SW = 2 * T_FRAC_BITS + 1;
  localparam int WB = 3 * T_FRAC_BITS + 1;
  localparam int PW = SW + TW;

  localparam logic [TW-1:0]   T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic [WB+1:0]   W_ONE = {2'b01, {(3 * T_FRAC_BITS){1'b0}}};

  logic [TW-1:0]   t_sat;
  logic [TW-1:0]   m_in;
  logic [2*TW-1:0] mm_full;
  logic [2*TW-1:0] tt_full;

  // stage 1 registers
  logic [TW-1:0] t1;
  logic [TW-1:0] m1;
  logic [SW-1:0] mm1;
  logic [SW-1:0] tt1;

  logic [PW-1:0] p0;
  logic [PW-1:0] p1;
  logic [PW-1:0] p2;
  logic [PW-1:0] p3;
  logic [PW:0]   p1x3;
  logic [PW:0]   p2x3;
  logic [WB+1:0] wsum;

  // t above one saturates to one
  always_comb begin
    t_sat   = (t_param > T_ONE) ? T_ONE : t_param;
    m_in    = T_ONE - t_sat;
    mm_full = m_in * m_in;
    tt_full = t_sat * t_sat;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      t1  <= t_sat;
      m1  <= m_in;
      mm1 <= mm_full[SW-1:0];
      tt1 <= tt_full[SW-1:0];
    end
  end

  always_comb begin
    p0   = mm1 * m1;
    p1   = mm1 * t1;
    p2   = tt1 * m1;
    p3   = tt1 * t1;
    p1x3 = {p1, 1'b0} + {1'b0, p1};
    p2x3 = {p2, 1'b0} + {1'b0, p2};
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      weight[0] <= p0[WB-1:0];
      weight[1] <= p1x3[WB-1:0];
      weight[2] <= p2x3[WB-1:0];
      weight[3] <= p3[WB-1:0];
    end
  end

  assign wsum = {2'b00, weight[0]} + {2'b00, weight[1]}
              + {2'b00, weight[2]} + {2'b00, weight[3]};

  // the four weights always add up to exactly one
  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    ld[1] |=> wsum == W_ONE)
    else $error("bernstein weights do not sum to one");

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    ld[0] |=> ({1'b0, t1} + {1'b0, m1}) == {1'b0, T_ONE})
    else $error("t and 1-t out of step");

  a_t_sat: assert property (@(posedge clk) disable iff (rst)
    ld[0] && (t_param > T_ONE) |=> m1 == '0)
    else $error("t above one not saturated");

endmodule

@@ rtl/bez_axis.sv @@
// one coordinate axis: split products, partial sums, accumulate, truncate
// takes weights from bez_weight; depends on bez_pkg for default widths
`timescale 1ns / 1ps

module bez_axis #(
  parameter int COORD_BITS  = bez_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = bez_pkg::T_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic [3:0]                         ld,
  input  logic [3:0][3*T_FRAC_BITS:0]        weight,
  input  logic signed [COORD_BITS-1:0]       c0,
  input  logic signed [COORD_BITS-1:0]       c1,
  input  logic signed [COORD_BITS-1:0]       c2,
  input  logic signed [COORD_BITS-1:0]       c3,
  output logic signed [COORD_BITS-1:0]       point
);
  import bez_pkg::*;

  localparam int WB  = 3 * T_FRAC_BITS + 1;
  localparam int SH  = 3 * T_FRAC_BITS;
  localparam int LO  = WB / 2;
  localparam int HI  = WB - LO;
  localparam int PLW = COORD_BITS + LO + 1;
  localparam int PHW = COORD_BITS + HI + 1;
  localparam int SLW = PLW + 2;
  localparam int SHW = PHW + 2;
  localparam int ACC = COORD_BITS + WB + 2;

  localparam logic [ACC-1:0] BIAS = {{(ACC - SH){1'b0}}, {SH{1'b1}}};

  logic signed [COORD_BITS-1:0] coord [4];

  logic signed [PLW-1:0] plo_next [4];
  logic signed [PHW-1:0] phi_next [4];
  logic signed [PLW-1:0] plo [4];
  logic signed [PHW-1:0] phi [4];

  logic signed [SLW-1:0] lo_sum_next;
  logic signed [SHW-1:0] hi_sum_next;
  logic signed [SLW-1:0] lo_sum;
  logic signed [SHW-1:0] hi_sum;

  logic signed [ACC-1:0] hi_ext;
  logic signed [ACC-1:0] lo_ext;
  logic signed [ACC-1:0] acc_next;
  logic signed [ACC-1:0] acc;
  logic [ACC-1:0]        biased;

  assign coord[0] = c0;
  assign coord[1] = c1;
  assign coord[2] = c2;
  assign coord[3] = c3;

  // weights are split into low and high halves to keep multipliers narrow
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      plo_next[i] = coord[i] * $signed({1'b0, weight[i][LO-1:0]});
      phi_next[i] = coord[i] * $signed({1'b0, weight[i][WB-1:LO]});
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int i = 0; i < 4; i++) begin
        plo[i] <= plo_next[i];
        phi[i] <= phi_next[i];
      end
    end
  end

  always_comb begin
    lo_sum_next = SLW'(plo[0]) + SLW'(plo[1]) + SLW'(plo[2]) + SLW'(plo[3]);
    hi_sum_next = SHW'(phi[0]) + SHW'(phi[1]) + SHW'(phi[2]) + SHW'(phi[3]);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      lo_sum <= lo_sum_next;
      hi_sum <= hi_sum_next;
    end
  end

  always_comb begin
    hi_ext   = ACC'(hi_sum);
    lo_ext   = ACC'(lo_sum);
    acc_next = (hi_ext <<< LO) + lo_ext;
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      acc <= acc_next;
    end
  end

  // adding scale-1 to a negative sum turns the floor shift into a truncation
  assign biased = acc + (acc[ACC-1] ? BIAS : '0);

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      point <= biased[SH +: COORD_BITS];
    end
  end

endmodule
